>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion wrappers used by the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion on clk, disabled while rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication built on the clocked form.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

>>> rtl/cfrg_pkg.sv
// ----------------------------------------------------------------------------
// cfrg_pkg
// Types and constants of the command freshness and replay guard.
// ----------------------------------------------------------------------------
`default_nettype none

package cfrg_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned TIMEOUT_W = 31;

  localparam logic [WORD_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_HEARTBEAT = 2'd1,
    OP_COMMAND   = 2'd2,
    OP_EPOCH     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED       = 3'd0,
    ST_BOOTSTRAP      = 3'd1,
    ST_MISMATCH       = 3'd2,
    ST_REPLAY         = 3'd3,
    ST_EXPIRED        = 3'd4,
    ST_REQUIRED       = 3'd5,
    ST_NOT_CONFIGURED = 3'd6
  } status_t;

  typedef struct packed {
    logic              proof_qualified;
    logic              pending_valid;
    logic [WORD_W-1:0] pending_heartbeat;
    logic [WORD_W-1:0] pending_since;
    logic [WORD_W-1:0] last_proof_time;
    logic              consumed_valid;
    logic [WORD_W-1:0] last_consumed;
    logic [WORD_W-1:0] ok_total;
    logic [WORD_W-1:0] mismatch_total;
    logic [WORD_W-1:0] timeout_total;
    logic [WORD_W-1:0] replay_total;
    logic [WORD_W-1:0] largest_gap;
  } guard_state_t;

  typedef struct packed {
    status_t           status;
    logic [WORD_W-1:0] ok_count;
    logic [WORD_W-1:0] mismatch_count;
    logic [WORD_W-1:0] timeout_count;
    logic [WORD_W-1:0] replay_count;
    logic [WORD_W-1:0] max_gap;
  } guard_result_t;

  function automatic logic [WORD_W-1:0] sat_inc(input logic [WORD_W-1:0] value);
    sat_inc = (value == COUNT_MAX) ? value : value + WORD_W'(1);
  endfunction

endpackage

`default_nettype wire

>>> rtl/cfrg_core.sv
// ----------------------------------------------------------------------------
// cfrg_core
// Next-state and status logic for one event of the replay guard.
// ----------------------------------------------------------------------------
`default_nettype none

module cfrg_core import cfrg_pkg::*; (
  input  wire op_t                   op,
  input  wire logic [WORD_W-1:0]     cmd_id,
  input  wire logic [WORD_W-1:0]     ack_ref,
  input  wire logic [WORD_W-1:0]     now,
  input  wire logic [TIMEOUT_W-1:0]  timeout,
  input  wire guard_state_t          state_cur,
  output guard_state_t               state_nxt,
  output status_t                    status
);

  logic [WORD_W-1:0] timeout_ext;
  logic [WORD_W-1:0] pending_age;
  logic [WORD_W-1:0] proof_age;
  logic [WORD_W-1:0] id_delta;
  logic              not_configured;
  logic              expired;
  logic              replay;
  logic              proof_fresh;

  assign timeout_ext    = {1'b0, timeout};
  assign pending_age    = now - state_cur.pending_since;
  assign proof_age      = now - state_cur.last_proof_time;
  assign id_delta       = cmd_id - state_cur.last_consumed;
  assign not_configured = (timeout == '0);
  assign expired        = state_cur.pending_valid && (pending_age > timeout_ext);
  assign replay         = (cmd_id == '0) ||
                          (state_cur.consumed_valid &&
                           ((id_delta == '0) || id_delta[WORD_W-1]));
  assign proof_fresh    = state_cur.proof_qualified && state_cur.pending_valid &&
                          (proof_age <= timeout_ext);

  always_comb begin
    state_nxt = state_cur;
    status    = ST_ACCEPTED;
    case (op)
      OP_TICK: begin
        if (expired) begin
          state_nxt.proof_qualified   = 1'b0;
          state_nxt.pending_valid     = 1'b0;
          state_nxt.pending_heartbeat = '0;
          state_nxt.pending_since     = '0;
          state_nxt.last_proof_time   = '0;
          if (state_cur.proof_qualified) begin
            state_nxt.timeout_total = sat_inc(state_cur.timeout_total);
          end
        end
      end
      OP_HEARTBEAT: begin
        if (not_configured) begin
          status = ST_NOT_CONFIGURED;
        end else begin
          if (expired) begin
            state_nxt.proof_qualified   = 1'b0;
            state_nxt.pending_valid     = 1'b0;
            state_nxt.pending_heartbeat = '0;
            state_nxt.pending_since     = '0;
            state_nxt.last_proof_time   = '0;
            if (state_cur.proof_qualified) begin
              state_nxt.timeout_total = sat_inc(state_cur.timeout_total);
            end
          end
          if (replay) begin
            state_nxt.replay_total = sat_inc(state_cur.replay_total);
            status                 = ST_REPLAY;
          end else begin
            state_nxt.consumed_valid = 1'b1;
            state_nxt.last_consumed  = cmd_id;
            if (!state_nxt.pending_valid) begin
              state_nxt.pending_valid     = 1'b1;
              state_nxt.pending_heartbeat = cmd_id;
              state_nxt.pending_since     = now;
              status                      = ST_BOOTSTRAP;
            end else if (ack_ref != state_cur.pending_heartbeat) begin
              state_nxt.mismatch_total = sat_inc(state_cur.mismatch_total);
              status                   = ST_MISMATCH;
            end else begin
              if (state_cur.proof_qualified && (proof_age > state_cur.largest_gap)) begin
                state_nxt.largest_gap = proof_age;
              end
              state_nxt.proof_qualified   = 1'b1;
              state_nxt.last_proof_time   = now;
              state_nxt.pending_heartbeat = cmd_id;
              state_nxt.pending_since     = now;
              state_nxt.ok_total          = sat_inc(state_cur.ok_total);
            end
          end
        end
      end
      OP_COMMAND: begin
        if (not_configured) begin
          status = ST_NOT_CONFIGURED;
        end else if (replay) begin
          state_nxt.replay_total = sat_inc(state_cur.replay_total);
          status                 = ST_REPLAY;
        end else begin
          state_nxt.consumed_valid = 1'b1;
          state_nxt.last_consumed  = cmd_id;
          if (expired) begin
            state_nxt.proof_qualified   = 1'b0;
            state_nxt.pending_valid     = 1'b0;
            state_nxt.pending_heartbeat = '0;
            state_nxt.pending_since     = '0;
            state_nxt.last_proof_time   = '0;
            if (state_cur.proof_qualified) begin
              state_nxt.timeout_total = sat_inc(state_cur.timeout_total);
            end
            status = ST_EXPIRED;
          end else if (proof_fresh) begin
            status = ST_ACCEPTED;
          end else begin
            status = ST_REQUIRED;
          end
        end
      end
      OP_EPOCH: begin
        state_nxt.proof_qualified   = 1'b0;
        state_nxt.pending_valid     = 1'b0;
        state_nxt.pending_heartbeat = '0;
        state_nxt.pending_since     = '0;
        state_nxt.last_proof_time   = '0;
        state_nxt.consumed_valid    = 1'b0;
        state_nxt.last_consumed     = '0;
      end
      default: begin
        state_nxt = state_cur;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/command_freshness_replay_guard.sv
// ----------------------------------------------------------------------------
// command_freshness_replay_guard: each input word is registered, then its result word is registered.
// Throughput is one word per cycle while the result side is not stalled; cfrg_core computes the state update.
// Synchronous active-low reset clears all guard state, counters and the timeout.
// ----------------------------------------------------------------------------
`default_nettype none

module command_freshness_replay_guard import cfrg_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [30:0]          cfg_wr_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           in_operation,
  input  wire logic [31:0]          in_command_id,
  input  wire logic [31:0]          in_ack_reference,
  input  wire logic [31:0]          in_event_time,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [2:0]                out_status,
  output logic [31:0]               out_proof_ok_count,
  output logic [31:0]               out_mismatch_count,
  output logic [31:0]               out_timeout_count,
  output logic [31:0]               out_replay_count,
  output logic [31:0]               out_max_proof_gap
);

  logic                  in_valid_r;
  op_t                   in_op_r;
  logic [WORD_W-1:0]     in_id_r;
  logic [WORD_W-1:0]     in_ack_r;
  logic [WORD_W-1:0]     in_time_r;
  logic [TIMEOUT_W-1:0]  timeout_r;
  guard_state_t          state_r;
  guard_state_t          state_nxt;
  status_t               status_nxt;
  logic                  out_valid_r;
  guard_result_t         result_r;
  logic                  advance;

  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_op_r   <= op_t'(in_operation);
      in_id_r   <= in_command_id;
      in_ack_r  <= in_ack_reference;
      in_time_r <= in_event_time;
    end
  end

  cfrg_core u_core (
    .op        (in_op_r),
    .cmd_id    (in_id_r),
    .ack_ref   (in_ack_r),
    .now       (in_time_r),
    .timeout   (timeout_r),
    .state_cur (state_r),
    .state_nxt (state_nxt),
    .status    (status_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= '0;
      state_r   <= '0;
    end else if (cfg_wr_en) begin
      timeout_r <= cfg_wr_data;
      state_r   <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_r.status         <= status_nxt;
      result_r.ok_count       <= state_nxt.ok_total;
      result_r.mismatch_count <= state_nxt.mismatch_total;
      result_r.timeout_count  <= state_nxt.timeout_total;
      result_r.replay_count   <= state_nxt.replay_total;
      result_r.max_gap        <= state_nxt.largest_gap;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = result_r.status;
  assign out_proof_ok_count = result_r.ok_count;
  assign out_mismatch_count = result_r.mismatch_count;
  assign out_timeout_count  = result_r.timeout_count;
  assign out_replay_count   = result_r.replay_count;
  assign out_max_proof_gap  = result_r.max_gap;

endmodule

`default_nettype wire

>>> rtl/cfrg_checker.sv
// ----------------------------------------------------------------------------
// cfrg_checker
// Port-level checks of the replay guard, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cfrg_checker import cfrg_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_stall,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [2:0]  out_status,
  input  wire logic [31:0] out_proof_ok_count,
  input  wire logic [31:0] out_mismatch_count,
  input  wire logic [31:0] out_timeout_count,
  input  wire logic [31:0] out_replay_count,
  input  wire logic [31:0] out_max_proof_gap
);

  logic out_held;
  logic replay_word;
  logic unconfigured_word;
  logic counters_clear;

  assign out_held          = out_valid && out_stall;
  assign replay_word       = out_valid && (out_status == ST_REPLAY);
  assign unconfigured_word = out_valid && (out_status == ST_NOT_CONFIGURED);
  assign counters_clear    = (out_proof_ok_count == '0) && (out_mismatch_count == '0) &&
                             (out_timeout_count == '0) && (out_replay_count == '0) &&
                             (out_max_proof_gap == '0);

  // A stalled result word stays valid and keeps its status.
  `ASSERT_CLK(a_out_hold, out_held |=> (out_valid && $stable(out_status)), "held word changed")

  // The input side only stalls when the result side is stalled.
  `ASSERT_IMPLIES(a_stall_source, !out_stall, !in_stall, "input stalled without output stall")

  `ASSERT_IMPLIES(a_replay_counted, replay_word, out_replay_count != '0, "replay not counted")

  // While unconfigured nothing can have been counted since the last clear.
  `ASSERT_IMPLIES(a_unconfigured_clean, unconfigured_word, counters_clear, "unconfigured counts")

endmodule

bind command_freshness_replay_guard cfrg_checker u_cfrg_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_status         (out_status),
  .out_proof_ok_count (out_proof_ok_count),
  .out_mismatch_count (out_mismatch_count),
  .out_timeout_count  (out_timeout_count),
  .out_replay_count   (out_replay_count),
  .out_max_proof_gap  (out_max_proof_gap)
);

`default_nettype wire
